@@ hw/rtl/rau_pkg.sv @@
// Package: shared types and constants of the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned MagWidth     = 64;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrZeroDen  = 2'd1,
    ErrOverflow = 2'd2
  } err_e;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic                zero_den;
    logic                num_neg;
    logic                den_neg;
    logic [MagWidth-1:0] num_mag;
    logic [MagWidth-1:0] den_mag;
    logic                lt;
    logic                eq;
    logic                gt;
  } job_t;

  typedef struct packed {
    logic [63:0] result_num;
    logic [62:0] result_den;
    logic        a_less;
    logic        a_equal;
    logic        a_greater;
    logic [1:0]  error_code;
  } res_t;

endpackage

@@ hw/rtl/rau_if.sv @@
// Interfaces: valid/ready channels for input items and result items.
interface rau_in_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [1:0]   command;
  logic [W-1:0] num_a;
  logic [W-1:0] den_a;
  logic [W-1:0] num_b;
  logic [W-1:0] den_b;
  modport source (output valid, command, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, command, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_num;
  logic [62:0] result_den;
  logic        a_less;
  logic        a_equal;
  logic        a_greater;
  logic [1:0]  error_code;
  modport source (output valid, result_num, result_den, a_less, a_equal, a_greater,
                  error_code, input ready);
  modport sink   (input valid, result_num, result_den, a_less, a_equal, a_greater,
                  error_code, output ready);
endinterface

@@ hw/rtl/rau_front.sv @@
// Front part: takes an item, forms the unreduced result and the comparison.
module rau_front #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [OPERAND_WIDTH-1:0] num_a_i,
  input  logic [OPERAND_WIDTH-1:0] den_a_i,
  input  logic [OPERAND_WIDTH-1:0] num_b_i,
  input  logic [OPERAND_WIDTH-1:0] den_b_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output rau_pkg::job_t        job_o
);
  import rau_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StSum  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;
  cmd_e       cmd_q;
  logic [W-1:0] na_q, da_q, nb_q, db_q;
  logic [MagWidth-1:0] p0_q, p1_q, p2_q;   // products, magnitudes
  logic p0n_q, p1n_q, p2n_q;
  logic signed [MagWidth-1:0] lhs_q, rhs_q;
  job_t job_q;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Operand pair for each product, chosen by command.
  logic [W-1:0] m0a, m0b, m1a, m1b;
  logic         s0, s1;
  always_comb begin
    unique case (cmd_q)
      CmdMul: begin
        m0a = na_q; m0b = nb_q; m1a = da_q; m1b = db_q;
      end
      CmdDiv: begin
        m0a = na_q; m0b = db_q; m1a = da_q; m1b = nb_q;
      end
      default: begin
        m0a = na_q; m0b = db_q; m1a = nb_q; m1b = da_q;
      end
    endcase
    s0 = m0a[W-1] ^ m0b[W-1];
    s1 = m1a[W-1] ^ m1b[W-1];
  end

  logic [MagWidth-1:0] sum_mag;
  logic                sum_neg, t_neg;
  always_comb begin
    t_neg = p1n_q ^ (cmd_q == CmdSub);
    if (p0n_q == t_neg) begin
      sum_mag = p0_q + p1_q; sum_neg = p0n_q;
    end else if (p0_q >= p1_q) begin
      sum_mag = p0_q - p1_q; sum_neg = p0n_q;
    end else begin
      sum_mag = p1_q - p0_q; sum_neg = t_neg;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StMul;
      StMul:  state_d = StSum;
      StSum:  state_d = StOut;
      StOut:  if (job_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      cmd_q <= cmd_e'(command_i);
      na_q <= num_a_i; da_q <= den_a_i; nb_q <= num_b_i; db_q <= den_b_i;
    end
    if (state_q == StMul) begin
      p0_q  <= MagWidth'(mag_of(m0a)) * MagWidth'(mag_of(m0b));
      p1_q  <= MagWidth'(mag_of(m1a)) * MagWidth'(mag_of(m1b));
      p2_q  <= MagWidth'(mag_of(da_q)) * MagWidth'(mag_of(db_q));
      p0n_q <= s0; p1n_q <= s1; p2n_q <= da_q[W-1] ^ db_q[W-1];
      lhs_q <= MagWidth'($signed(na_q)) * MagWidth'($signed(db_q));
      rhs_q <= MagWidth'($signed(nb_q)) * MagWidth'($signed(da_q));
    end
    if (state_q == StSum) begin
      job_q.zero_den <= (da_q == '0) || (db_q == '0) || (cmd_q == CmdDiv && nb_q == '0);
      job_q.eq <= (lhs_q == rhs_q) && da_q != '0 && db_q != '0;
      job_q.lt <= (lhs_q != rhs_q) && ((lhs_q < rhs_q) != (da_q[W-1] != db_q[W-1]))
                  && da_q != '0 && db_q != '0;
      job_q.gt <= (lhs_q != rhs_q) && ((lhs_q < rhs_q) == (da_q[W-1] != db_q[W-1]))
                  && da_q != '0 && db_q != '0;
      if (cmd_q == CmdAdd || cmd_q == CmdSub) begin
        job_q.num_mag <= sum_mag;
        job_q.num_neg <= sum_neg && sum_mag != '0;
        job_q.den_mag <= p2_q;
        job_q.den_neg <= p2n_q;
      end else begin
        job_q.num_mag <= p0_q;
        job_q.num_neg <= p0n_q;
        job_q.den_mag <= p1_q;
        job_q.den_neg <= p1n_q;
      end
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign job_valid_o = (state_q == StOut);
  assign job_o       = job_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !job_ready_i) |=> state_q == StOut)
    else $error("front dropped a job");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == StMul)
    else $error("front did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && job_valid_o))
    else $error("front busy and idle");
endmodule

@@ hw/rtl/rau_queue.sv @@
// Two-entry queue between the front and back parts.
module rau_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  rau_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output rau_pkg::job_t rd_data_o
);
  import rau_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr_en) wptr_q <= ~wptr_q;
      if (rd_en) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wptr_q] <= wr_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count missed a write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && !wr_en) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("queue count missed a read");
endmodule

@@ hw/rtl/rau_back.sv @@
// Back part: binary gcd, two restoring divisions, sign and overflow handling.
module rau_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  rau_pkg::job_t job_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output rau_pkg::res_t res_o
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(MagWidth + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGcd  = 3'd1;
  localparam logic [2:0] StDivN = 3'd2;
  localparam logic [2:0] StDivD = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q;
  job_t       job_q;
  logic [MagWidth-1:0] u_q, v_q;      // binary gcd operands
  logic [CW-1:0]       sh_q;          // shared power of two
  logic [MagWidth-1:0] g_q;
  logic [MagWidth-1:0] quo_q, rem_q, nm_q, dm_q;
  logic [CW-1:0]       cnt_q;
  res_t                res_q;

  logic [MagWidth:0]   trial;
  logic [MagWidth-1:0] dividend;
  assign dividend = (state_q == StDivN) ? job_q.num_mag : job_q.den_mag;
  assign trial = {rem_q, dividend[cnt_q[CW-2:0]]} - {1'b0, g_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (job_valid_i) state_q <= job_i.zero_den ? StFin : StGcd;
        StGcd: begin
          if (u_q == '0 || v_q == '0) state_q <= StDivN;
        end
        StDivN: if (cnt_q == '0) state_q <= StDivD;
        StDivD: if (cnt_q == '0) state_q <= StFin;
        StFin:  state_q <= StOut;
        StOut:  if (res_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        job_q <= job_i;
        u_q   <= job_i.num_mag;
        v_q   <= job_i.den_mag;
        sh_q  <= '0;
      end
      StGcd: begin
        if (u_q == '0 || v_q == '0) begin
          g_q   <= (u_q | v_q) << sh_q;
          cnt_q <= CW'(MagWidth - 1);
          rem_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1; v_q <= v_q >> 1; sh_q <= sh_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= (u_q - v_q) >> 1;
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
      end
      StDivN, StDivD: begin
        if (!trial[MagWidth]) begin
          rem_q <= trial[MagWidth-1:0];
          quo_q <= {quo_q[MagWidth-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[MagWidth-2:0], dividend[cnt_q[CW-2:0]]};
          quo_q <= {quo_q[MagWidth-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          cnt_q <= CW'(MagWidth - 1);
          rem_q <= '0;
          if (state_q == StDivN) begin
            nm_q <= {quo_q[MagWidth-2:0], ~trial[MagWidth]};
          end else begin
            dm_q <= {quo_q[MagWidth-2:0], ~trial[MagWidth]};
          end
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      StFin: begin
        res_q.a_less    <= job_q.lt;
        res_q.a_equal   <= job_q.eq;
        res_q.a_greater <= job_q.gt;
        if (job_q.zero_den) begin
          res_q.result_num <= '0; res_q.result_den <= '0; res_q.error_code <= ErrZeroDen;
        end else if ((job_q.num_neg != job_q.den_neg) && nm_q != '0) begin
          res_q.result_num <= ~nm_q + 1'b1;
          res_q.result_den <= dm_q[62:0];
          res_q.error_code <= ErrNone;
        end else if (nm_q[MagWidth-1]) begin
          res_q.result_num <= '0; res_q.result_den <= '0; res_q.error_code <= ErrOverflow;
        end else begin
          res_q.result_num <= nm_q;
          res_q.result_den <= dm_q[62:0];
          res_q.error_code <= ErrNone;
        end
      end
      default: ;
    endcase
  end

  assign job_ready_o = (state_q == StIdle);
  assign res_valid_o = (state_q == StOut);
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !res_ready_i) |=> state_q == StOut && $stable(res_q))
    else $error("back changed a held result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StGcd |-> sh_q <= CW'(MagWidth))
    else $error("gcd shift out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |-> $countones({res_q.a_less, res_q.a_equal, res_q.a_greater}) <= 1)
    else $error("comparison flags conflict");
endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// Top level: rational arithmetic unit with gcd reduction.
// Usage: one input channel carries a command (add, subtract, multiply,
// divide) and two signed fractions; one output channel carries the reduced
// fraction, less/equal/greater flags of a against b, and an error code.
// Each input item yields exactly one result item, in order.
// The front part takes an item, forms the exact products and sum in its
// multiply and sum states, and hands a job through a two-entry queue to
// the back part. The back part runs a binary gcd, then two bit-serial
// divisions, and takes its next job only once its result is taken; the
// back part sets the rate.
// An item with a zero denominator, or a division by zero, skips the gcd and
// the divisions and comes out through the final and output states.
// While the back part works, the front part can take and prepare up to
// three further items. A result waits in an output register until taken;
// a stalled receiver stalls the back part, then the queue, then the input.
// Reset clears all control state; no items are held after reset.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_if,
  rau_out_if.source out_if
);
  import rau_pkg::*;

  logic job_valid, job_ready, q_valid, q_ready, res_valid;
  job_t job, q_job;
  res_t res;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .command_i(in_if.command),
    .num_a_i(in_if.num_a[OPERAND_WIDTH-1:0]), .den_a_i(in_if.den_a[OPERAND_WIDTH-1:0]),
    .num_b_i(in_if.num_b[OPERAND_WIDTH-1:0]), .den_b_i(in_if.den_b[OPERAND_WIDTH-1:0]),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  rau_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(job_valid), .wr_ready_o(job_ready), .wr_data_i(job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  rau_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .res_valid_o(res_valid), .res_ready_i(out_if.ready), .res_o(res)
  );

  assign out_if.valid      = res_valid;
  assign out_if.result_num = res.result_num;
  assign out_if.result_den = res.result_den;
  assign out_if.a_less     = res.a_less;
  assign out_if.a_equal    = res.a_equal;
  assign out_if.a_greater  = res.a_greater;
  assign out_if.error_code = res.error_code;
endmodule
